// ===== rtl/nrc_pkg.sv =====
`default_nettype none
// ============================================================================
// nrc_pkg
// Shared constants and controller/datapath interface types of the
// nonce replay cache.
// ============================================================================
package nrc_pkg;

    localparam int WINDOW   = 16;
    localparam int IDX_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W    = $clog2(WINDOW + 1);
    localparam int ID_W     = 32;
    localparam int WORD_W   = 64;
    localparam int ENTRY_W  = ID_W + 3 * WORD_W;
    localparam int FILL_W   = 5;

    localparam logic OP_CHECK    = 1'b0;
    localparam logic OP_REMEMBER = 1'b1;

    typedef struct packed {
        logic load;
        logic write;
        logic scan;
    } nrc_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic scan_last;
    } nrc_stat_t;

endpackage
`default_nettype wire

// ===== rtl/nrc_ram.sv =====
`default_nettype none
// ============================================================================
// nrc_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module nrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic                                       re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== rtl/nrc_datapath.sv =====
`default_nettype none
// ============================================================================
// nrc_datapath
// Key capture, entry store, ring pointer, fill count and scan compare.
// ============================================================================
module nrc_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire nrc_pkg::nrc_cmd_t             cmd,
    output nrc_pkg::nrc_stat_t                 stat,
    input  wire logic [nrc_pkg::ID_W-1:0]      auth_id,
    input  wire logic [nrc_pkg::WORD_W-1:0]    nonce_low,
    input  wire logic [nrc_pkg::WORD_W-1:0]    nonce_mid,
    input  wire logic [nrc_pkg::WORD_W-1:0]    nonce_high,
    output logic                               seen,
    output logic [nrc_pkg::FILL_W-1:0]         fill_count
);
    import nrc_pkg::*;

    logic [ENTRY_W-1:0] key_reg;
    logic [IDX_W-1:0]   wptr_reg, wptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   addr_reg, addr_next;
    logic               cmp_valid_reg;
    logic               hit_reg, hit_next;
    logic [ENTRY_W-1:0] in_entry;
    logic [ENTRY_W-1:0] rd_entry;

    assign in_entry = {auth_id, nonce_high, nonce_mid, nonce_low};

    nrc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (WINDOW)
    ) u_store (
        .clk   (clk),
        .we    (cmd.write),
        .waddr (wptr_reg),
        .wdata (in_entry),
        .re    (cmd.scan),
        .raddr (addr_reg),
        .rdata (rd_entry)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= in_entry;
        end
    end

    always_comb
    begin
        wptr_next  = wptr_reg;
        count_next = count_reg;
        if (cmd.write)
        begin
            if (wptr_reg == IDX_W'(WINDOW - 1))
                wptr_next = '0;
            else
                wptr_next = wptr_reg + 1'b1;
            if (count_reg != CNT_W'(WINDOW))
                count_next = count_reg + 1'b1;
        end
    end

    always_comb
    begin
        addr_next = addr_reg;
        hit_next  = hit_reg;
        if (cmd.load)
        begin
            addr_next = '0;
            hit_next  = 1'b0;
        end
        else
        begin
            if (cmd.scan)
                addr_next = addr_reg + 1'b1;
            if (cmp_valid_reg && (rd_entry == key_reg))
                hit_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg      <= '0;
            count_reg     <= '0;
            addr_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            wptr_reg      <= wptr_next;
            count_reg     <= count_next;
            addr_reg      <= addr_next;
            cmp_valid_reg <= cmd.scan;
            hit_reg       <= hit_next;
        end
    end

    assign stat.count_zero = (count_reg == '0);
    assign stat.scan_last  = ((CNT_W'(addr_reg) + 1'b1) == count_reg);

    assign seen       = hit_reg;
    assign fill_count = FILL_W'(count_reg);

endmodule
`default_nettype wire

// ===== rtl/nrc_ctrl.sv =====
`default_nettype none
// ============================================================================
// nrc_ctrl
// Transaction sequencer: accept, remember or scan, then one result strobe.
// ============================================================================
module nrc_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 operation,
    input  wire nrc_pkg::nrc_stat_t   stat,
    output nrc_pkg::nrc_cmd_t         cmd,
    output logic                      busy,
    output logic                      done
);
    import nrc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (operation == OP_REMEMBER)
                    begin
                        cmd.write  = 1'b1;
                        state_next = ST_DONE;
                    end
                    else if (stat.count_zero)
                        state_next = ST_DONE;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

endmodule
`default_nettype wire

// ===== rtl/nonce_replay_cache.sv =====
`default_nettype none
// ============================================================================
// nonce_replay_cache
// Anti-replay cache of (auth id, 24-byte nonce) pairs in a ring window.
// ----------------------------------------------------------------------------
// Request: a transaction is taken on a rising edge with start high and busy
// low; operation, auth_id and nonce_low/mid/high are sampled on that edge.
// operation = 1 writes the pair at the ring pointer (the oldest slot once
// the window is full); operation = 0 looks the pair up among filled slots.
// Result: done is high for exactly one cycle with seen and fill_count
// valid; seen is always 0 for a remember. The receiver cannot stall.
// Sequence from the accepting edge: a remember, or a check of an empty
// cache, gives done in the next cycle; a check reads the filled slots in
// ST_SCAN (one slot read per cycle through the single RAM read port),
// compares the last read in ST_DRAIN, then gives done in ST_DONE, and
// returns to idle before the next start is taken.
// Reset: asynchronous, clears pointer and fill count; the cache is empty.
// Entry storage is not cleared, only slots below the fill count are read.
// ============================================================================
module nonce_replay_cache (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          operation,
    input  wire logic [nrc_pkg::ID_W-1:0]      auth_id,
    input  wire logic [nrc_pkg::WORD_W-1:0]    nonce_low,
    input  wire logic [nrc_pkg::WORD_W-1:0]    nonce_mid,
    input  wire logic [nrc_pkg::WORD_W-1:0]    nonce_high,
    output logic                               done,
    output logic                               seen,
    output logic [nrc_pkg::FILL_W-1:0]         fill_count
);
    import nrc_pkg::*;

    nrc_cmd_t  cmd;
    nrc_stat_t stat;

    nrc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done)
    );

    nrc_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .auth_id    (auth_id),
        .nonce_low  (nonce_low),
        .nonce_mid  (nonce_mid),
        .nonce_high (nonce_high),
        .seen       (seen),
        .fill_count (fill_count)
    );

endmodule
`default_nettype wire
